@@ sv/pmq_pkg.sv @@
// Shared constants and types for the priority mailbox queue.
`default_nettype none
package pmq_pkg;

  localparam int LEVELS_DEF      = 4;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int MSG_WIDTH_DEF   = 64;

  localparam int OPCODE_W   = 3;
  localparam int LEVEL_IN_W = 3;
  localparam int STATUS_W   = 3;
  localparam int OUT_LVL_W  = 2;
  localparam int COUNT_W    = 7;
  localparam int SCHED_W    = 2;
  localparam int CFG_W      = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SIZE    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FLUSH   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd5;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_LEVEL = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_WRONG     = 3'd4;

  localparam logic [SCHED_W-1:0] SCHED_IDLE     = 2'd0;
  localparam logic [SCHED_W-1:0] SCHED_QUEUED   = 2'd1;
  localparam logic [SCHED_W-1:0] SCHED_ACQUIRED = 2'd2;

  localparam logic               REG_ACTIVE_LEVELS = 1'b0;
  localparam logic [CFG_W-1:0]   ACTIVE_LEVELS_RST = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_take;
    logic op_flush;
    logic any_ne;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ sv/priority_mailbox_queue_core.sv @@
// Top level of the priority mailbox queue.
//
// Strict-priority mailbox with one circular FIFO per level in a single
// message store, plus an idle/queued/acquired scheduling state. Operations
// are taken one at a time. Each is accepted, executed and then written to
// the output register once that is free; a pop with a message reads the
// store in the execute step through a registered read. A flush of N
// messages reads them through the single store read port and presents
// them back to back while the output is not stalled. A finished result
// is held in the output register until it is taken.
// Level count is set through the APB register at address 0 and should only
// be written while the block is idle.
`default_nettype none
module priority_mailbox_queue_core
  import pmq_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int MSG_WIDTH   = MSG_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [LEVEL_IN_W-1:0] push_level_i,
  input  wire logic [MSG_WIDTH-1:0]  push_message_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [STATUS_W-1:0]   status_o,
  output logic                       message_valid_o,
  output logic      [MSG_WIDTH-1:0]  out_message_o,
  output logic      [OUT_LVL_W-1:0]  out_level_o,
  output logic      [COUNT_W-1:0]    total_count_o,
  output logic                       post_request_o,
  output logic      [SCHED_W-1:0]    mailbox_state_o,
  output logic                       last_o
);

  logic [CFG_W-1:0] active_levels;
  cmd_t             cmd;
  stat_t            stat;

  pmq_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .active_levels_o (active_levels)
  );

  pmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  pmq_dpath #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .MSG_WIDTH   (MSG_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .active_levels_i (active_levels),
    .opcode_i        (opcode_i),
    .push_level_i    (push_level_i),
    .push_message_i  (push_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .message_valid_o (message_valid_o),
    .out_message_o   (out_message_o),
    .out_level_o     (out_level_o),
    .total_count_o   (total_count_o),
    .post_request_o  (post_request_o),
    .mailbox_state_o (mailbox_state_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

@@ sv/pmq_regs.sv @@
// APB configuration register: active level count.
`default_nettype none
module pmq_regs
  import pmq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [CFG_W-1:0]   active_levels_o
);

  logic [CFG_W-1:0] active_q, active_d;
  logic             hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_ACTIVE_LEVELS);
  assign pready = 1'b1;
  assign prdata = hit ? PDATA_W'(active_q) : '0;

  always_comb begin
    active_d = active_q;
    if (psel && penable && pwrite && hit) begin
      active_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_LEVELS_RST;
    end else begin
      active_q <= active_d;
    end
  end

  assign active_levels_o = active_q;

endmodule
`default_nettype wire

@@ sv/pmq_ctrl.sv @@
// Operation sequencer for the priority mailbox queue.
`default_nettype none
module pmq_ctrl
  import pmq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire stat_t stat_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.op_take && stat_i.any_ne) begin
          cmd_o.take = 1'b1;
        end else begin
          cmd_o.exec = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.op_flush && stat_i.any_ne) begin
            cmd_o.take = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/pmq_dpath.sv @@
// Level FIFOs, message store, scheduling state and result register.
`default_nettype none
module pmq_dpath
  import pmq_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int MSG_WIDTH   = MSG_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output stat_t                      stat_o,
  input  wire logic [CFG_W-1:0]      active_levels_i,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [LEVEL_IN_W-1:0] push_level_i,
  input  wire logic [MSG_WIDTH-1:0]  push_message_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [STATUS_W-1:0]   status_o,
  output logic                       message_valid_o,
  output logic      [MSG_WIDTH-1:0]  out_message_o,
  output logic      [OUT_LVL_W-1:0]  out_level_o,
  output logic      [COUNT_W-1:0]    total_count_o,
  output logic                       post_request_o,
  output logic      [SCHED_W-1:0]    mailbox_state_o,
  output logic                       last_o
);

  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W   = $clog2(LEVEL_DEPTH);
  localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int EFF_W   = CFG_W + 1;

  logic [MSG_WIDTH-1:0] mem [ENTRIES];
  logic [MSG_WIDTH-1:0] rdata_q;

  logic [PTR_W-1:0]  head_q [LEVELS];
  logic [PTR_W-1:0]  head_d [LEVELS];
  logic [PTR_W-1:0]  tail_q [LEVELS];
  logic [PTR_W-1:0]  tail_d [LEVELS];
  logic [FILL_W-1:0] fill_q [LEVELS];
  logic [FILL_W-1:0] fill_d [LEVELS];
  logic [SCHED_W-1:0] sched_q, sched_d;

  logic [OPCODE_W-1:0]   op_q;
  logic [LEVEL_IN_W-1:0] lvl_q;
  logic [MSG_WIDTH-1:0]  msg_q;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_valid_q, res_valid_d;
  logic [LVL_W-1:0]    res_level_q, res_level_d;
  logic                res_post_q, res_post_d;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  o_status_q;
  logic                 o_mvalid_q;
  logic [MSG_WIDTH-1:0] o_msg_q;
  logic [OUT_LVL_W-1:0] o_level_q;
  logic [COUNT_W-1:0]   o_count_q;
  logic                 o_post_q;
  logic [SCHED_W-1:0]   o_sched_q;
  logic                 o_last_q;

  logic [EFF_W-1:0]  eff;
  logic [LEVELS-1:0] active;
  logic [LEVELS-1:0] ne_mask;
  logic              any_ne;
  logic [LVL_W-1:0]  sel_lvl;
  logic [CNT_W-1:0]  cnt;
  logic [LVL_W-1:0]  push_idx;
  logic              level_ok;
  logic              is_flush;
  logic              out_free;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;

  assign eff = ({1'b0, active_levels_i} < EFF_W'(LEVELS)) ? {1'b0, active_levels_i}
                                                           : EFF_W'(LEVELS);
  assign push_idx = lvl_q[LVL_W-1:0];
  assign level_ok = ({1'b0, lvl_q} < eff);
  assign is_flush = (op_q == OP_FLUSH);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cnt     = '0;
    sel_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      active[i]  = (EFF_W'(i) < eff);
      ne_mask[i] = active[i] && (fill_q[i] != '0);
      if (active[i]) begin
        cnt = cnt + CNT_W'(fill_q[i]);
      end
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_mask[i]) begin
        sel_lvl = LVL_W'(i);
      end
    end
  end

  assign any_ne = |ne_mask;

  assign stat_o.op_take  = (op_q == OP_POP) || is_flush;
  assign stat_o.op_flush = is_flush;
  assign stat_o.any_ne   = any_ne;
  assign stat_o.out_free = out_free;

  assign waddr = ADDR_W'(push_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_q[push_idx]);
  assign raddr = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_q[sel_lvl]);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    sched_d      = sched_q;
    res_status_d = res_status_q;
    res_valid_d  = res_valid_q;
    res_level_d  = res_level_q;
    res_post_d   = res_post_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    if (cmd_i.exec) begin
      res_status_d = STS_OK;
      res_valid_d  = 1'b0;
      res_level_d  = '0;
      res_post_d   = 1'b0;
      case (op_q)
        OP_PUSH: begin
          if (!level_ok) begin
            res_status_d = STS_BAD_LEVEL;
          end else if (fill_q[push_idx] >= FILL_W'(LEVEL_DEPTH)) begin
            res_status_d = STS_FULL;
          end else begin
            mem_we           = 1'b1;
            tail_d[push_idx] = (tail_q[push_idx] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                               : tail_q[push_idx] + 1'b1;
            fill_d[push_idx] = fill_q[push_idx] + 1'b1;
            if (sched_q == SCHED_IDLE) begin
              sched_d    = SCHED_QUEUED;
              res_post_d = 1'b1;
            end
          end
        end
        OP_POP, OP_FLUSH: res_status_d = STS_EMPTY;
        OP_ACQUIRE: begin
          if (sched_q == SCHED_QUEUED) begin
            sched_d = SCHED_ACQUIRED;
          end else begin
            res_status_d = STS_WRONG;
          end
        end
        OP_RELEASE: begin
          if (sched_q == SCHED_ACQUIRED) begin
            res_post_d = (cnt != '0);
            sched_d    = (cnt != '0) ? SCHED_QUEUED : SCHED_IDLE;
          end else begin
            res_status_d = STS_WRONG;
          end
        end
        default: res_status_d = STS_OK;
      endcase
    end
    if (cmd_i.take) begin
      mem_re          = 1'b1;
      head_d[sel_lvl] = (head_q[sel_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                        : head_q[sel_lvl] + 1'b1;
      fill_d[sel_lvl] = fill_q[sel_lvl] - 1'b1;
      res_status_d    = STS_OK;
      res_valid_d     = 1'b1;
      res_level_d     = sel_lvl;
      res_post_d      = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= msg_q;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
      sched_q     <= SCHED_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      lvl_q <= push_level_i;
      msg_q <= push_message_i;
    end
    res_status_q <= res_status_d;
    res_valid_q  <= res_valid_d;
    res_level_q  <= res_level_d;
    res_post_q   <= res_post_d;
    if (cmd_i.emit) begin
      o_status_q <= res_status_q;
      o_mvalid_q <= res_valid_q;
      o_msg_q    <= res_valid_q ? rdata_q : '0;
      o_level_q  <= res_valid_q ? OUT_LVL_W'(res_level_q) : '0;
      o_count_q  <= is_flush ? '0 : COUNT_W'(cnt);
      o_post_q   <= res_post_q;
      o_sched_q  <= sched_q;
      o_last_q   <= (is_flush && res_valid_q) ? !any_ne : 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign message_valid_o = o_mvalid_q;
  assign out_message_o   = o_msg_q;
  assign out_level_o     = o_level_q;
  assign total_count_o   = o_count_q;
  assign post_request_o  = o_post_q;
  assign mailbox_state_o = o_sched_q;
  assign last_o          = o_last_q;

endmodule
`default_nettype wire

@@ sv/pmq_checker.sv @@
// Port-level assertions for the priority mailbox queue, bound to the top level.
`default_nettype none
module pmq_checker
  import pmq_pkg::*;
#(
  parameter int MSG_WIDTH = MSG_WIDTH_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [STATUS_W-1:0]  status_o,
  input wire logic                 message_valid_o,
  input wire logic [MSG_WIDTH-1:0] out_message_o,
  input wire logic [COUNT_W-1:0]   total_count_o,
  input wire logic                 last_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_message_o) && $stable(last_o))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an operation is in progress");

  // a flush still streaming keeps the input closed
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input opened in the middle of a flush");

  // only a flush gives non-final results, and it leaves every active level empty
  a_flush_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |->
      message_valid_o && status_o == STS_OK && total_count_o == '0)
    else $error("malformed flush result");

endmodule

bind priority_mailbox_queue_core pmq_checker #(
  .MSG_WIDTH (MSG_WIDTH)
) u_pmq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .message_valid_o (message_valid_o),
  .out_message_o   (out_message_o),
  .total_count_o   (total_count_o),
  .last_o          (last_o)
);
`default_nettype wire

@@ test/tb_priority_mailbox_queue_core.sv @@
// Self-checking testbench for the priority mailbox queue core: directed and random traffic.
`timescale 1ns / 1ps
module tb_priority_mailbox_queue_core;
  import pmq_pkg::*;

  localparam int NUM_LEVELS  = LEVELS_DEF;
  localparam int DEPTH       = LEVEL_DEPTH_DEF;
  localparam int MSG_W       = MSG_WIDTH_DEF;
  localparam int IDLE_PCT    = 36;
  localparam int PHASE_ITEMS = 56;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 mvalid;
    logic [MSG_W-1:0]     message;
    logic [OUT_LVL_W-1:0] level;
    logic [COUNT_W-1:0]   count;
    logic                 post;
    logic [SCHED_W-1:0]   state;
    logic                 last;
  } reply_t;

  class mailbox_scoreboard;
    logic [MSG_W-1:0]   store [NUM_LEVELS][DEPTH];
    int unsigned        head [NUM_LEVELS];
    int unsigned        tail [NUM_LEVELS];
    int unsigned        fill [NUM_LEVELS];
    logic [SCHED_W-1:0] sched;
    logic [CFG_W-1:0]   levels_cfg;
    reply_t             due [$];
    int unsigned        errors;

    function new();
      foreach (fill[i]) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
      sched      = SCHED_IDLE;
      levels_cfg = ACTIVE_LEVELS_RST;
      errors     = 0;
    endfunction

    function int unsigned level_limit();
      return (levels_cfg < NUM_LEVELS) ? int'(levels_cfg) : NUM_LEVELS;
    endfunction

    // messages visible in the active levels
    function int unsigned held();
      int unsigned n;
      n = 0;
      for (int i = 0; i < level_limit(); i++) n += fill[i];
      return n;
    endfunction

    function logic [MSG_W-1:0] take(int unsigned lv);
      logic [MSG_W-1:0] word;
      word     = store[lv][head[lv]];
      head[lv] = (head[lv] + 1) % DEPTH;
      fill[lv]--;
      return word;
    endfunction

    function reply_t make_reply(logic [STATUS_W-1:0] status, logic mvalid,
                                logic [MSG_W-1:0] message, int unsigned lv,
                                logic post, logic last);
      reply_t r;
      r         = '0;
      r.status  = status;
      r.mvalid  = mvalid;
      r.message = message;
      r.level   = OUT_LVL_W'(lv);
      r.post    = post;
      r.last    = last;
      return r;
    endfunction

    function void apply_operation(logic [OPCODE_W-1:0] op, logic [LEVEL_IN_W-1:0] lv,
                                  logic [MSG_W-1:0] message);
      reply_t      batch [$];
      reply_t      r;
      int unsigned lim;
      logic        post;
      lim  = level_limit();
      post = 1'b0;
      case (op)
        OP_PUSH: begin
          if (lv >= lim) begin
            batch.push_back(make_reply(STS_BAD_LEVEL, 1'b0, '0, 0, 1'b0, 1'b1));
          end else if (fill[lv] >= DEPTH) begin
            batch.push_back(make_reply(STS_FULL, 1'b0, '0, 0, 1'b0, 1'b1));
          end else begin
            store[lv][tail[lv]] = message;
            tail[lv] = (tail[lv] + 1) % DEPTH;
            fill[lv]++;
            if (sched == SCHED_IDLE) begin
              sched = SCHED_QUEUED;
              post  = 1'b1;
            end
            batch.push_back(make_reply(STS_OK, 1'b0, '0, 0, post, 1'b1));
          end
        end
        OP_POP: begin
          for (int i = 0; i < lim; i++) begin
            if (fill[i] != 0 && batch.size() == 0)
              batch.push_back(make_reply(STS_OK, 1'b1, take(i), i, 1'b0, 1'b1));
          end
          if (batch.size() == 0)
            batch.push_back(make_reply(STS_EMPTY, 1'b0, '0, 0, 1'b0, 1'b1));
        end
        OP_FLUSH: begin
          for (int i = 0; i < lim; i++) begin
            while (fill[i] != 0)
              batch.push_back(make_reply(STS_OK, 1'b1, take(i), i, 1'b0, 1'b0));
          end
          if (batch.size() == 0) begin
            batch.push_back(make_reply(STS_EMPTY, 1'b0, '0, 0, 1'b0, 1'b1));
          end else begin
            r      = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
          end
        end
        OP_ACQUIRE: begin
          if (sched == SCHED_QUEUED) begin
            sched = SCHED_ACQUIRED;
            batch.push_back(make_reply(STS_OK, 1'b0, '0, 0, 1'b0, 1'b1));
          end else begin
            batch.push_back(make_reply(STS_WRONG, 1'b0, '0, 0, 1'b0, 1'b1));
          end
        end
        OP_RELEASE: begin
          if (sched == SCHED_ACQUIRED) begin
            post  = (held() != 0);
            sched = post ? SCHED_QUEUED : SCHED_IDLE;
            batch.push_back(make_reply(STS_OK, 1'b0, '0, 0, post, 1'b1));
          end else begin
            batch.push_back(make_reply(STS_WRONG, 1'b0, '0, 0, 1'b0, 1'b1));
          end
        end
        default: begin
          batch.push_back(make_reply(STS_OK, 1'b0, '0, 0, 1'b0, 1'b1));
        end
      endcase
      foreach (batch[k]) begin
        r       = batch[k];
        r.count = COUNT_W'(held());
        r.state = sched;
        due.push_back(r);
      end
    endfunction

    function void compare(string field, logic [MSG_W-1:0] want, logic [MSG_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual status %0d message %0h",
                 $time, got.status, got.message);
        errors++;
        return;
      end
      want = due.pop_front();
      compare("status", want.status, got.status);
      compare("message_valid", want.mvalid, got.mvalid);
      compare("out_message", want.message, got.message);
      compare("out_level", want.level, got.level);
      compare("total_count", want.count, got.count);
      compare("post_request", want.post, got.post);
      compare("mailbox_state", want.state, got.state);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [PADDR_W-1:0]    paddr          = '0;
  logic [PDATA_W-1:0]    pwdata         = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [OPCODE_W-1:0]   opcode_i       = OP_SIZE;
  logic [LEVEL_IN_W-1:0] push_level_i   = '0;
  logic [MSG_W-1:0]      push_message_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic                  message_valid_o;
  logic [MSG_W-1:0]      out_message_o;
  logic [OUT_LVL_W-1:0]  out_level_o;
  logic [COUNT_W-1:0]    total_count_o;
  logic                  post_request_o;
  logic [SCHED_W-1:0]    mailbox_state_o;
  logic                  last_o;

  bit                    steady      = 1'b0;
  int unsigned           items_sent  = 0;
  int unsigned           cycle_count = 0;
  mailbox_scoreboard     sb          = new();

  priority_mailbox_queue_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply('{status: status_o, mvalid: message_valid_o, message: out_message_o,
                       level: out_level_o, count: total_count_o, post: post_request_o,
                       state: mailbox_state_o, last: last_o});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    return gap;
  endfunction

  function automatic logic [MSG_W-1:0] rand_msg();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEVEL_IN_W-1:0] any_level();
    return LEVEL_IN_W'($urandom_range(7));
  endfunction

  // mostly levels that are in use, sometimes any level
  function automatic logic [LEVEL_IN_W-1:0] pick_level();
    int unsigned lim;
    lim = sb.level_limit();
    if (lim > 0 && $urandom_range(9) < 8) return LEVEL_IN_W'($urandom_range(lim - 1));
    return any_level();
  endfunction

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [LEVEL_IN_W-1:0] lv,
                           logic [MSG_W-1:0] message);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    push_level_i   <= lv;
    push_message_i <= message;
    do @(posedge clk_i); while (!in_ready_o);
    sb.apply_operation(op, lv, message);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // write then read back the level count
  task automatic program_levels(logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_LEVELS, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.levels_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(value)) begin
      $display("%0t: prdata mismatch, expected %0h, actual %0h", $time, value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_level(logic [LEVEL_IN_W-1:0] lv);
    repeat (DEPTH + 1) send_item(OP_PUSH, lv, rand_msg());
  endtask

  // post, acquire, work, release
  task automatic run_session();
    int unsigned pick;
    repeat ($urandom_range(1, 6)) send_item(OP_PUSH, pick_level(), rand_msg());
    send_item(OP_ACQUIRE, any_level(), rand_msg());
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(9);
      if (pick < 4) send_item(OP_POP, any_level(), rand_msg());
      else if (pick < 7) send_item(OP_PUSH, pick_level(), rand_msg());
      else if (pick < 8) send_item(OP_SIZE, any_level(), rand_msg());
      else if (pick < 9) send_item(OP_FLUSH, any_level(), rand_msg());
      else send_item(OP_RELEASE, any_level(), rand_msg());
    end
    send_item(OP_RELEASE, any_level(), rand_msg());
  endtask

  task automatic run_phase(logic [CFG_W-1:0] value, bit no_idle);
    int unsigned stop_at;
    int unsigned pick;
    settle();
    program_levels(value);
    steady  = no_idle;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) run_session();
      else if (pick < 60) fill_level(pick_level());
      else if (pick < 70) send_item(OP_FLUSH, any_level(), rand_msg());
      else send_item(OPCODE_W'($urandom_range(7)), pick_level(), rand_msg());
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_SIZE, '0, '0);
    send_item(OP_POP, '1, '1);
    send_item(OP_FLUSH, '0, '0);
    send_item(OP_ACQUIRE, '0, '0);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_PUSH, 3'd3, '1);
    send_item(OP_PUSH, 3'd0, '0);
    send_item(OP_PUSH, 3'd4, rand_msg());
    send_item(OP_PUSH, 3'd7, rand_msg());
    send_item(OP_SPARE_LO, '1, rand_msg());
    send_item(OP_SPARE_HI, '0, rand_msg());
    send_item(OP_ACQUIRE, '0, '0);
    send_item(OP_ACQUIRE, '0, '0);
    send_item(OP_PUSH, 3'd1, rand_msg());
    send_item(OP_POP, '0, '0);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_FLUSH, '0, '0);
    send_item(OP_ACQUIRE, '0, '0);
    send_item(OP_RELEASE, '0, '0);

    // lowering the count leaves messages hidden in the upper levels
    run_phase(3'd4, 1'b0);
    run_phase(3'd1, 1'b0);
    run_phase(3'd7, 1'b1);
    run_phase(3'd0, 1'b0);
    run_phase(3'd2, 1'b0);
    run_phase(3'd3, 1'b0);

    // every level to the brim, then one flush drains the lot
    settle();
    program_levels(3'd4);
    send_item(OP_FLUSH, any_level(), rand_msg());
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      repeat (DEPTH + 1) send_item(OP_PUSH, LEVEL_IN_W'(lv), rand_msg());
    end
    send_item(OP_FLUSH, any_level(), rand_msg());

    settle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pmq_pkg.sv
sv/pmq_regs.sv
sv/pmq_ctrl.sv
sv/pmq_dpath.sv
sv/priority_mailbox_queue_core.sv
sv/pmq_checker.sv
test/tb_priority_mailbox_queue_core.sv
